// File: sv/mp2a_pkg.sv
// ----------------------------------------------------------------------------
// mp2a_pkg
// Shared constants for the 2-D max pooling block: sequencer codes and
// configuration register indexes.
// ----------------------------------------------------------------------------
package mp2a_pkg;

    typedef logic [2:0] state_t;

    localparam state_t ST_IDLE  = 3'd0;
    localparam state_t ST_ROW   = 3'd1;
    localparam state_t ST_COL   = 3'd2;
    localparam state_t ST_SCAN  = 3'd3;
    localparam state_t ST_DRAIN = 3'd4;
    localparam state_t ST_PUSH  = 3'd5;
    localparam state_t ST_FLUSH = 3'd6;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PLANE_HEIGHT  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLANE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_SIZE     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BORDER_PAD    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLANE_COUNT   = 3'd6;

endpackage

// File: sv/mp2a_ram.sv
// ----------------------------------------------------------------------------
// mp2a_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mp2a_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/max_pool_2d_with_argmax.sv
// A request is written to the line store when it is accepted; each finished
// window then takes a column test, a scan over every kernel position, a drain and a push.
// A new request is taken only in the idle state, after the previous one has
// finished its row tests, column tests, windows and flush.
// Reset (aresetn low, synchronous) restores the default registers and
// clears counters, sequencer and output; the line store is not cleared.
// ----------------------------------------------------------------------------
// max_pool_2d_with_argmax
// Streaming 2-D max pooling with argmax over raster-ordered sample planes,
// with padding, stride, and a line store of the most recent kernel rows.
// ----------------------------------------------------------------------------
module max_pool_2d_with_argmax #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int MAX_KERNEL  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [SAMPLE_BITS-1:0]       m_max_value,
    output logic [5:0]                          m_window_index,
    output logic                                m_last_of_run,
    output logic                                m_last_of_plane,
    output logic                                m_last_of_batch,
    input  logic                                cfg_we,
    input  logic [mp2a_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [mp2a_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import mp2a_pkg::*;

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int RB = $clog2(MAX_HEIGHT);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int SB = $clog2(MAX_KERNEL);
    localparam int PW = ((RB > CB) ? RB : CB) + 3;
    localparam int AB = SB + CB;

    // configuration
    logic [10:0] cfg_h_reg, cfg_w_reg;
    logic [3:0]  cfg_kh_reg, cfg_kw_reg, cfg_s_reg;
    logic [2:0]  cfg_pad_reg;
    logic [15:0] cfg_pc_reg;

    logic [HB-1:0] h_w;
    logic [WB-1:0] w_w;
    logic [3:0]    kh_w, kw_w, s_w, pr_w, pc_w;
    logic [15:0]   pcnt_w;

    always_comb begin
        if (cfg_h_reg == 11'd0) begin
            h_w = HB'(1);
        end else if (32'(cfg_h_reg) > MAX_HEIGHT) begin
            h_w = HB'(MAX_HEIGHT);
        end else begin
            h_w = HB'(cfg_h_reg);
        end
        if (cfg_w_reg == 11'd0) begin
            w_w = WB'(1);
        end else if (32'(cfg_w_reg) > MAX_WIDTH) begin
            w_w = WB'(MAX_WIDTH);
        end else begin
            w_w = WB'(cfg_w_reg);
        end
        if (cfg_kh_reg == 4'd0) begin
            kh_w = 4'd1;
        end else if (32'(cfg_kh_reg) > MAX_KERNEL) begin
            kh_w = 4'(MAX_KERNEL);
        end else begin
            kh_w = cfg_kh_reg;
        end
        if (cfg_kw_reg == 4'd0) begin
            kw_w = 4'd1;
        end else if (32'(cfg_kw_reg) > MAX_KERNEL) begin
            kw_w = 4'(MAX_KERNEL);
        end else begin
            kw_w = cfg_kw_reg;
        end
        s_w    = (cfg_s_reg == 4'd0) ? 4'd1 : cfg_s_reg;
        pr_w   = ({1'b0, cfg_pad_reg} < kh_w - 4'd1) ? {1'b0, cfg_pad_reg} : kh_w - 4'd1;
        pc_w   = ({1'b0, cfg_pad_reg} < kw_w - 4'd1) ? {1'b0, cfg_pad_reg} : kw_w - 4'd1;
        pcnt_w = (cfg_pc_reg == 16'd0) ? 16'd1 : cfg_pc_reg;
    end

    logic signed [PW-1:0] ec_init, er_init;
    assign ec_init = PW'(pc_w) + PW'(1) - PW'(kw_w);
    assign er_init = PW'(pr_w) + PW'(1) - PW'(kh_w);

    // stream position
    logic [RB-1:0]        r_reg, r_next;
    logic [CB-1:0]        c_reg, c_next;
    logic [15:0]          plane_reg, plane_next;
    logic [SB-1:0]        slot_reg, slot_next;
    logic signed [PW-1:0] ec_reg, ec_next, er_reg, er_next;
    logic [3:0]           phc_reg, phc_next, phr_reg, phr_next;

    logic signed [PW-1:0] cur_ec, cur_er;
    logic [3:0]           cur_phc, cur_phr;
    assign cur_ec  = (c_reg == '0) ? ec_init : ec_reg;
    assign cur_phc = (c_reg == '0) ? 4'd0 : phc_reg;
    assign cur_er  = (r_reg == '0) ? er_init : er_reg;
    assign cur_phr = (r_reg == '0) ? 4'd0 : phr_reg;

    // per-request latch
    logic [RB-1:0]        lat_r_reg, lat_r_next;
    logic [SB-1:0]        lat_slot_reg, lat_slot_next;
    logic [15:0]          lat_plane_reg, lat_plane_next;
    logic                 lat_lcol_reg, lat_lcol_next, lat_lrow_reg, lat_lrow_next;
    logic signed [PW-1:0] base_ec_reg, base_ec_next;
    logic [3:0]           base_phc_reg, base_phc_next;

    // sequencer
    state_t               state_reg, state_next;
    logic [2:0]           jr_reg, jr_next, jc_reg, jc_next;
    logic signed [PW-1:0] str_reg, str_next, stc_reg, stc_next;
    logic [3:0]           prh_reg, prh_next, pch_reg, pch_next;
    logic [3:0]           kh_reg, kh_next, kw_reg, kw_next;
    logic [5:0]           idx_reg, idx_next;
    logic signed [PW-1:0] rr_reg, rr_next, cc_reg, cc_next;
    logic [SB-1:0]        ss_reg, ss_next;

    // compare stage
    logic                          p_valid_reg, p_valid_next, p_inb_reg, p_inb_next;
    logic                          p_first_reg, p_first_next;
    logic [5:0]                    p_idx_reg, p_idx_next;
    logic signed [SAMPLE_BITS-1:0] best_reg, best_next;
    logic [5:0]                    bidx_reg, bidx_next;

    // pending and output
    logic                          pend_v_reg, pend_v_next;
    logic signed [SAMPLE_BITS-1:0] pend_val_reg, pend_val_next;
    logic [5:0]                    pend_idx_reg, pend_idx_next;
    logic                          pend_lop_reg, pend_lop_next, pend_lob_reg, pend_lob_next;
    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0] m_val_reg, m_val_next;
    logic [5:0]                    m_idx_reg, m_idx_next;
    logic                          m_run_reg, m_run_next, m_lop_reg, m_lop_next;
    logic                          m_lob_reg, m_lob_next;

    // line store
    logic                          ram_we, ram_re;
    logic [AB-1:0]                 ram_waddr, ram_raddr;
    logic [SAMPLE_BITS-1:0]        ram_rdata;

    mp2a_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (1 << AB)
    ) u_line_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_sample),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic accept, out_free;
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign ram_we    = accept;
    assign ram_waddr = {slot_reg, c_reg};
    assign ram_re    = (state_reg == ST_SCAN);
    assign ram_raddr = {ss_reg, cc_reg[CB-1:0]};

    logic                          row_ok, col_ok, inb;
    logic [2:0]                    jr_max, jc_max;
    logic [PW-1:0]                 row_gap;
    logic [SB-1:0]                 slot0;
    logic                          row_last, col_last, res_lop, res_lob;
    logic signed [SAMPLE_BITS-1:0] cmp_v;
    logic                          do_col_adv, do_row_adv;

    always_comb begin
        row_ok = !str_reg[PW-1] && (prh_reg == 4'd0);
        col_ok = !stc_reg[PW-1] && (pch_reg == 4'd0);
        jr_max = lat_lrow_reg ? pr_w[2:0] : 3'd0;
        jc_max = lat_lcol_reg ? pc_w[2:0] : 3'd0;
        row_gap = PW'(lat_r_reg) - PW'(str_reg) + PW'(pr_w);
        slot0  = (lat_slot_reg >= row_gap[SB-1:0]) ? lat_slot_reg - row_gap[SB-1:0]
                 : SB'(32'(lat_slot_reg) + MAX_KERNEL - 32'(row_gap[SB-1:0]));
        inb    = !rr_reg[PW-1] && !cc_reg[PW-1] && (rr_reg < PW'(h_w))
                 && (cc_reg < PW'(w_w));
        row_last = (PW'(str_reg) + PW'(s_w) + PW'(kh_w)) > (PW'(h_w) + PW'(pr_w) + PW'(pr_w));
        col_last = (PW'(stc_reg) + PW'(s_w) + PW'(kw_w)) > (PW'(w_w) + PW'(pc_w) + PW'(pc_w));
        res_lop  = row_last && col_last;
        res_lob  = res_lop && ((17'(lat_plane_reg) + 17'd1) >= 17'(pcnt_w));
        cmp_v    = p_inb_reg ? $signed(ram_rdata) : '0;
    end

    always_comb begin
        r_next = r_reg; c_next = c_reg; plane_next = plane_reg; slot_next = slot_reg;
        ec_next = ec_reg; er_next = er_reg; phc_next = phc_reg; phr_next = phr_reg;
        lat_r_next = lat_r_reg; lat_slot_next = lat_slot_reg;
        lat_plane_next = lat_plane_reg; lat_lcol_next = lat_lcol_reg;
        lat_lrow_next = lat_lrow_reg; base_ec_next = base_ec_reg;
        base_phc_next = base_phc_reg;
        state_next = state_reg; jr_next = jr_reg; jc_next = jc_reg;
        str_next = str_reg; stc_next = stc_reg; prh_next = prh_reg; pch_next = pch_reg;
        kh_next = kh_reg; kw_next = kw_reg; idx_next = idx_reg;
        rr_next = rr_reg; cc_next = cc_reg; ss_next = ss_reg;
        p_valid_next = 1'b0; p_inb_next = p_inb_reg; p_first_next = p_first_reg;
        p_idx_next = p_idx_reg; best_next = best_reg; bidx_next = bidx_reg;
        pend_v_next = pend_v_reg; pend_val_next = pend_val_reg;
        pend_idx_next = pend_idx_reg; pend_lop_next = pend_lop_reg;
        pend_lob_next = pend_lob_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_val_next = m_val_reg; m_idx_next = m_idx_reg; m_run_next = m_run_reg;
        m_lop_next = m_lop_reg; m_lob_next = m_lob_reg;
        do_col_adv = 1'b0; do_row_adv = 1'b0;

        if (p_valid_reg) begin
            if (p_first_reg || (cmp_v > best_reg)) begin
                best_next = cmp_v;
                bidx_next = p_idx_reg;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    lat_r_next     = r_reg;
                    lat_slot_next  = slot_reg;
                    lat_plane_next = plane_reg;
                    lat_lcol_next  = (WB'(c_reg) + WB'(1)) == w_w;
                    lat_lrow_next  = (HB'(r_reg) + HB'(1)) == h_w;
                    base_ec_next   = cur_ec;
                    base_phc_next  = cur_phc;
                    str_next = cur_er;
                    prh_next = cur_phr;
                    jr_next  = 3'd0;
                    state_next = ST_ROW;
                    ec_next  = cur_ec + PW'(1);
                    phc_next = cur_ec[PW-1] ? 4'd0
                               : ((cur_phc == s_w - 4'd1) ? 4'd0 : cur_phc + 4'd1);
                    if ((WB'(c_reg) + WB'(1)) == w_w) begin
                        c_next   = '0;
                        er_next  = cur_er + PW'(1);
                        phr_next = cur_er[PW-1] ? 4'd0
                                   : ((cur_phr == s_w - 4'd1) ? 4'd0 : cur_phr + 4'd1);
                        slot_next = (32'(slot_reg) == MAX_KERNEL - 1) ? '0 : slot_reg + SB'(1);
                        if ((HB'(r_reg) + HB'(1)) == h_w) begin
                            r_next = '0;
                            plane_next = ((17'(plane_reg) + 17'd1) >= 17'(pcnt_w)) ? 16'd0
                                         : plane_reg + 16'd1;
                        end else begin
                            r_next = r_reg + RB'(1);
                        end
                    end else begin
                        c_next = c_reg + CB'(1);
                    end
                end
            end
            ST_ROW: begin
                if (row_ok) begin
                    stc_next = base_ec_reg;
                    pch_next = base_phc_reg;
                    jc_next  = 3'd0;
                    state_next = ST_COL;
                end else begin
                    do_row_adv = 1'b1;
                end
            end
            ST_COL: begin
                if (col_ok) begin
                    kh_next  = 4'd0;
                    kw_next  = 4'd0;
                    idx_next = 6'd0;
                    rr_next  = str_reg - PW'(pr_w);
                    cc_next  = stc_reg - PW'(pc_w);
                    ss_next  = slot0;
                    state_next = ST_SCAN;
                end else begin
                    do_col_adv = 1'b1;
                end
            end
            ST_SCAN: begin
                p_valid_next = 1'b1;
                p_inb_next   = inb;
                p_idx_next   = idx_reg;
                p_first_next = (idx_reg == 6'd0);
                idx_next     = idx_reg + 6'd1;
                if (kw_reg == kw_w - 4'd1) begin
                    kw_next = 4'd0;
                    cc_next = stc_reg - PW'(pc_w);
                    kh_next = kh_reg + 4'd1;
                    rr_next = rr_reg + PW'(1);
                    ss_next = (32'(ss_reg) == MAX_KERNEL - 1) ? '0 : ss_reg + SB'(1);
                    if (kh_reg == kh_w - 4'd1) begin
                        state_next = ST_DRAIN;
                    end
                end else begin
                    kw_next = kw_reg + 4'd1;
                    cc_next = cc_reg + PW'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (!pend_v_reg || out_free) begin
                    if (pend_v_reg) begin
                        m_valid_next = 1'b1;
                        m_val_next = pend_val_reg;
                        m_idx_next = pend_idx_reg;
                        m_run_next = 1'b0;
                        m_lop_next = pend_lop_reg;
                        m_lob_next = pend_lob_reg;
                    end
                    pend_v_next   = 1'b1;
                    pend_val_next = best_reg;
                    pend_idx_next = bidx_reg;
                    pend_lop_next = res_lop;
                    pend_lob_next = res_lob;
                    do_col_adv    = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (!pend_v_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_val_next = pend_val_reg;
                    m_idx_next = pend_idx_reg;
                    m_run_next = 1'b1;
                    m_lop_next = pend_lop_reg;
                    m_lob_next = pend_lob_reg;
                    pend_v_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_col_adv) begin
            if (jc_reg == jc_max) begin
                do_row_adv = 1'b1;
            end else begin
                jc_next  = jc_reg + 3'd1;
                stc_next = stc_reg + PW'(1);
                pch_next = stc_reg[PW-1] ? 4'd0
                           : ((pch_reg == s_w - 4'd1) ? 4'd0 : pch_reg + 4'd1);
                state_next = ST_COL;
            end
        end
        if (do_row_adv) begin
            if (jr_reg == jr_max) begin
                state_next = ST_FLUSH;
            end else begin
                jr_next  = jr_reg + 3'd1;
                str_next = str_reg + PW'(1);
                prh_next = str_reg[PW-1] ? 4'd0
                           : ((prh_reg == s_w - 4'd1) ? 4'd0 : prh_reg + 4'd1);
                state_next = ST_ROW;
            end
        end

        if (cfg_we) begin
            r_next = '0; c_next = '0; plane_next = '0; slot_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_h_reg   <= 11'd32;
            cfg_w_reg   <= 11'd32;
            cfg_kh_reg  <= 4'd2;
            cfg_kw_reg  <= 4'd2;
            cfg_s_reg   <= 4'd2;
            cfg_pad_reg <= 3'd0;
            cfg_pc_reg  <= 16'd1;
            r_reg       <= '0;
            c_reg       <= '0;
            plane_reg   <= '0;
            slot_reg    <= '0;
            state_reg   <= ST_IDLE;
            p_valid_reg <= 1'b0;
            pend_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_PLANE_HEIGHT:  cfg_h_reg   <= cfg_data[10:0];
                    CFG_PLANE_WIDTH:   cfg_w_reg   <= cfg_data[10:0];
                    CFG_KERNEL_HEIGHT: cfg_kh_reg  <= cfg_data[3:0];
                    CFG_KERNEL_WIDTH:  cfg_kw_reg  <= cfg_data[3:0];
                    CFG_STEP_SIZE:     cfg_s_reg   <= cfg_data[3:0];
                    CFG_BORDER_PAD:    cfg_pad_reg <= cfg_data[2:0];
                    CFG_PLANE_COUNT:   cfg_pc_reg  <= cfg_data;
                    default: ;
                endcase
            end
            r_reg       <= (cfg_we && cfg_index > CFG_PLANE_COUNT) ? r_reg : r_next;
            c_reg       <= (cfg_we && cfg_index > CFG_PLANE_COUNT) ? c_reg : c_next;
            plane_reg   <= (cfg_we && cfg_index > CFG_PLANE_COUNT) ? plane_reg : plane_next;
            slot_reg    <= (cfg_we && cfg_index > CFG_PLANE_COUNT) ? slot_reg : slot_next;
            state_reg   <= state_next;
            p_valid_reg <= p_valid_next;
            pend_v_reg  <= pend_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ec_reg <= ec_next; er_reg <= er_next; phc_reg <= phc_next; phr_reg <= phr_next;
        lat_r_reg <= lat_r_next; lat_slot_reg <= lat_slot_next;
        lat_plane_reg <= lat_plane_next; lat_lcol_reg <= lat_lcol_next;
        lat_lrow_reg <= lat_lrow_next; base_ec_reg <= base_ec_next;
        base_phc_reg <= base_phc_next;
        jr_reg <= jr_next; jc_reg <= jc_next; str_reg <= str_next; stc_reg <= stc_next;
        prh_reg <= prh_next; pch_reg <= pch_next; kh_reg <= kh_next; kw_reg <= kw_next;
        idx_reg <= idx_next; rr_reg <= rr_next; cc_reg <= cc_next; ss_reg <= ss_next;
        p_inb_reg <= p_inb_next; p_first_reg <= p_first_next; p_idx_reg <= p_idx_next;
        best_reg <= best_next; bidx_reg <= bidx_next;
        pend_val_reg <= pend_val_next; pend_idx_reg <= pend_idx_next;
        pend_lop_reg <= pend_lop_next; pend_lob_reg <= pend_lob_next;
        m_val_reg <= m_val_next; m_idx_reg <= m_idx_next; m_run_reg <= m_run_next;
        m_lop_reg <= m_lop_next; m_lob_reg <= m_lob_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_max_value     = m_val_reg;
    assign m_window_index  = m_idx_reg;
    assign m_last_of_run   = m_run_reg;
    assign m_last_of_plane = m_lop_reg;
    assign m_last_of_batch = m_lob_reg;

endmodule

// File: sv/mp2a_checker.sv
// ----------------------------------------------------------------------------
// mp2a_checker
// Port-level checks for the max pooling block, bound to the top level.
// ----------------------------------------------------------------------------
module mp2a_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_max_value,
    input logic                          m_last_of_run,
    input logic                          m_last_of_plane,
    input logic                          m_last_of_batch
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_max_value))
        else $error("result changed while stalled");

    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while previous one in work");

    a_batch_in_plane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_of_batch |-> m_last_of_plane)
        else $error("batch end without plane end");

    a_plane_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_of_plane |-> m_last_of_run)
        else $error("plane end not last of run");

endmodule

bind max_pool_2d_with_argmax mp2a_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mp2a_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_max_value     (m_max_value),
    .m_last_of_run   (m_last_of_run),
    .m_last_of_plane (m_last_of_plane),
    .m_last_of_batch (m_last_of_batch)
);

// File: verif/max_pool_2d_with_argmax_test.sv
// ----------------------------------------------------------------------------
// max_pool_2d_with_argmax_test
// Self-checking bench for the streaming max pooling block: drives sample
// planes under several register settings with random idling on both
// channels, predicts every pooled result with argmax and plane/batch flags,
// and compares each result field by field in order.
// ----------------------------------------------------------------------------
module max_pool_2d_with_argmax_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mp2a_pkg::*;

    typedef struct packed {
        logic signed [15:0] max_value;
        logic [5:0]         window_index;
        logic               last_of_run;
        logic               last_of_plane;
        logic               last_of_batch;
    } pool_result_t;

    class pool_scoreboard;
        logic [10:0] plane_height, plane_width;
        logic [3:0]  kernel_height, kernel_width, step_size;
        logic [2:0]  border_pad;
        logic [15:0] plane_count;
        logic signed [15:0] lines [8][1024];
        int unsigned row_cnt, col_cnt, plane_cnt;
        pool_result_t expected_q[$];
        int errors;

        function new();
            plane_height = 32; plane_width = 32;
            kernel_height = 2; kernel_width = 2; step_size = 2;
            border_pad = 0; plane_count = 1;
            row_cnt = 0; col_cnt = 0; plane_cnt = 0;
            errors = 0;
        endfunction

        function void configure(logic [2:0] idx, logic [15:0] val);
            case (idx)
                CFG_PLANE_HEIGHT:  plane_height = val[10:0];
                CFG_PLANE_WIDTH:   plane_width = val[10:0];
                CFG_KERNEL_HEIGHT: kernel_height = val[3:0];
                CFG_KERNEL_WIDTH:  kernel_width = val[3:0];
                CFG_STEP_SIZE:     step_size = val[3:0];
                CFG_BORDER_PAD:    border_pad = val[2:0];
                CFG_PLANE_COUNT:   plane_count = val;
                default:           return;
            endcase
            row_cnt = 0; col_cnt = 0; plane_cnt = 0;
        endfunction

        function int clip(int v, int lo, int hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // windows along one axis whose last in-bounds position is pos
        function int axis_hits(int pos, int len, int k, int s, int p, output int starts[8]);
            int span, count, n, first_pos, end_pos, last_pos;
            n = 0;
            span = len + 2 * p;
            if (span < k) return 0;
            count = (span - k) / s + 1;
            for (int i = 0; i < count; i++) begin
                first_pos = i * s - p;
                end_pos = first_pos + k - 1;
                last_pos = end_pos < len - 1 ? end_pos : len - 1;
                if (last_pos == pos && n < 8) begin
                    starts[n] = i;
                    n++;
                end
            end
            return n;
        endfunction

        function void note_request(logic signed [15:0] smp);
            int h, w, kh, kw, s, pr, pc, pcnt, oh, ow, r, c, nr, nc, r0, c0, rr, cc;
            int rows[8], cols[8];
            int best, v, idx;
            bit first;
            pool_result_t res;
            h = clip(plane_height, 1, 1024);
            w = clip(plane_width, 1, 1024);
            kh = clip(kernel_height, 1, 8);
            kw = clip(kernel_width, 1, 8);
            s = step_size == 0 ? 1 : step_size;
            pr = border_pad < kh - 1 ? border_pad : kh - 1;
            pc = border_pad < kw - 1 ? border_pad : kw - 1;
            pcnt = plane_count == 0 ? 1 : plane_count;
            oh = h + 2 * pr < kh ? 0 : (h + 2 * pr - kh) / s + 1;
            ow = w + 2 * pc < kw ? 0 : (w + 2 * pc - kw) / s + 1;
            r = row_cnt % h;
            c = col_cnt % w;
            lines[r % 8][c] = smp;
            nr = axis_hits(r, h, kh, s, pr, rows);
            nc = axis_hits(c, w, kw, s, pc, cols);
            for (int a = 0; a < nr; a++) begin
                for (int b = 0; b < nc; b++) begin
                    r0 = rows[a] * s - pr;
                    c0 = cols[b] * s - pc;
                    best = 0; idx = 0; first = 1;
                    for (int i = 0; i < kh; i++) begin
                        for (int j = 0; j < kw; j++) begin
                            rr = r0 + i; cc = c0 + j; v = 0;
                            if (rr >= 0 && rr < h && cc >= 0 && cc < w)
                                v = lines[rr % 8][cc];
                            if (first || v > best) begin
                                best = v; idx = i * kw + j; first = 0;
                            end
                        end
                    end
                    res.max_value = best[15:0];
                    res.window_index = idx[5:0];
                    res.last_of_run = (a == nr - 1) && (b == nc - 1);
                    res.last_of_plane = (rows[a] == oh - 1) && (cols[b] == ow - 1);
                    res.last_of_batch = res.last_of_plane && (plane_cnt + 1 >= pcnt);
                    expected_q.push_back(res);
                end
            end
            col_cnt = c + 1;
            row_cnt = r;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
                if (row_cnt >= h) begin
                    row_cnt = 0;
                    plane_cnt++;
                    if (plane_cnt >= pcnt) plane_cnt = 0;
                end
            end
        endfunction

        function void check(pool_result_t got);
            pool_result_t exp_r;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: value %0d index %0d",
                                           got.max_value, got.window_index);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got != exp_r) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp val %0d idx %0d run %b plane %b batch %b,",
                              " got val %0d idx %0d run %b plane %b batch %b"},
                             exp_r.max_value, exp_r.window_index, exp_r.last_of_run,
                             exp_r.last_of_plane, exp_r.last_of_batch, got.max_value,
                             got.window_index, got.last_of_run, got.last_of_plane,
                             got.last_of_batch);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_valid, s_ready;
    logic signed [15:0] s_sample;
    logic m_valid, m_ready;
    logic signed [15:0] m_max_value;
    logic [5:0] m_window_index;
    logic m_last_of_run, m_last_of_plane, m_last_of_batch;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    pool_scoreboard sb = new();
    bit idling = 1;
    bit hold_req = 0;
    int random_items = 0;

    max_pool_2d_with_argmax dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_max_value(m_max_value),
        .m_window_index(m_window_index), .m_last_of_run(m_last_of_run),
        .m_last_of_plane(m_last_of_plane), .m_last_of_batch(m_last_of_batch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: check accepted results, stall in bursts
    initial begin
        int hold;
        pool_result_t got;
        hold = 0;
        m_ready <= 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got.max_value = m_max_value;
                got.window_index = m_window_index;
                got.last_of_run = m_last_of_run;
                got.last_of_plane = m_last_of_plane;
                got.last_of_batch = m_last_of_batch;
                sb.check(got);
            end
            if (hold_req) begin
                hold_req = 0;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 0;
            end else if (idling && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 19) - 1;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    task automatic set_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        sb.configure(idx, val);
        cfg_we <= 0;
    endtask

    task automatic set_all(int h, int w, int kh, int kw, int st, int pad, int cnt);
        set_reg(CFG_PLANE_HEIGHT, 16'(h));
        set_reg(CFG_PLANE_WIDTH, 16'(w));
        set_reg(CFG_KERNEL_HEIGHT, 16'(kh));
        set_reg(CFG_KERNEL_WIDTH, 16'(kw));
        set_reg(CFG_STEP_SIZE, 16'(st));
        set_reg(CFG_BORDER_PAD, 16'(pad));
        set_reg(CFG_PLANE_COUNT, 16'(cnt));
    endtask

    task automatic send_request(logic signed [15:0] smp);
        if (idling && $urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1;
        s_sample <= smp;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(smp);
    endtask

    task automatic settle();
        s_valid <= 0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] pick_sample(int mode);
        case (mode)
            0: return 16'($urandom());
            1: return 16'($signed($urandom_range(0, 4)) - 2);
            default: return 16'(-$signed({1'b0, $urandom_range(1, 3000)}));
        endcase
    endfunction

    initial begin
        logic signed [15:0] edge_vals[6];
        int h, w, cnt, n, mode;
        edge_vals = '{16'sh8000, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, -16'sd5};
        aresetn <= 0;
        s_valid <= 0;
        s_sample <= '0;
        cfg_we <= 0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // single-sample plane, 8x8 kernel, full padding: 64 windows per sample
        set_all(0, 1, 15, 8, 0, 7, 0);
        foreach (edge_vals[i]) send_request(edge_vals[i]);
        settle();

        // padded 3x4 planes, two per batch; unknown register index mid-plane
        set_all(3, 4, 2, 3, 1, 1, 2);
        for (int i = 0; i < 7; i++) send_request(edge_vals[i % 6]);
        settle();
        set_reg(3'd7, 16'hFFFF);
        for (int i = 0; i < 17; i++) send_request(pick_sample(i % 3));
        settle();

        // plane smaller than the kernel: no results
        set_all(2, 2, 5, 5, 1, 1, 1);
        for (int i = 0; i < 6; i++) send_request(pick_sample(0));
        settle();

        // tallest plane, one column wide
        set_all(2047, 1, 8, 1, 8, 0, 1);
        for (int i = 0; i < 100; i++) send_request(pick_sample(i % 3));
        settle();

        // widest plane, one row high
        set_all(1, 1024, 1, 8, 8, 0, 65535);
        for (int i = 0; i < 100; i++) send_request(pick_sample(i % 3));
        settle();

        while (random_items < 200) begin
            h = $urandom_range(1, 10);
            w = $urandom_range(1, 10);
            cnt = $urandom_range(1, 3);
            if ($urandom_range(0, 5) == 0)
                set_all(h, w, 8, $urandom_range(1, 8), $urandom_range(1, 8), 7, cnt);
            else
                set_all(h, w, $urandom_range(1, 4), $urandom_range(1, 4),
                        $urandom_range(1, 3), $urandom_range(0, 3), cnt);
            n = h * w * cnt;
            if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
            if (n > 120) n = 120;
            mode = $urandom_range(0, 2);
            if (random_items == 0) hold_req = 1;
            if (random_items > 130) idling = 0;
            for (int i = 0; i < n; i++) send_request(pick_sample(mode));
            random_items += n;
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
